### design/mpam_pkg.sv
`default_nettype none
package mpam_pkg;

    // fixed field widths
    localparam int COUNT_W = 16;
    localparam int TOTAL_W = 32;
    localparam int SYM_W   = 5;

    // transaction kinds
    typedef enum logic [1:0] {
        ACT_PATTERN = 2'd0,
        ACT_END     = 2'd1,
        ACT_BUILD   = 2'd2,
        ACT_QUERY   = 2'd3
    } action_t;

    // sequencer states
    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INS_RD,
        ST_INS_WR,
        ST_END_RD,
        ST_END_WR,
        ST_Q_RD,
        ST_Q_CNT,
        ST_Q_ACC,
        ST_R_RD,
        ST_R_WT,
        ST_B_QRD,
        ST_B_QWT,
        ST_B_FWT,
        ST_B_CF,
        ST_B_CU,
        ST_B_GRD,
        ST_B_GP,
        ST_B_GV
    } state_t;

endpackage
`default_nettype wire

### design/multi_pattern_automaton_matcher.sv
`default_nettype none
// Aho-Corasick matcher. A transaction is taken when start is high and busy is low; busy stays
// high while it is worked on, one at a time. A pattern symbol reads the goto memory, then
// follows or adds an edge; one outside the alphabet ends after the read. End of pattern reads,
// then writes the node count. A query symbol does a goto read, a count read, then accumulate.
// These steps follow a chain of dependent memory reads. A build first queues the children of
// the root, then walks every node of the trie breadth first, scanning each alphabet symbol.
// Once the automaton is built, trie edits and further builds are dropped in the cycle they
// are taken. After reset a clearing pass zeroes the goto, failure and count memories; busy
// is high throughout. A final query symbol puts match_total and table_full out with a
// one-cycle done strobe, which the receiver must take as it comes.
module multi_pattern_automaton_matcher
    import mpam_pkg::*;
#(
    parameter int NODES    = 4096,
    parameter int ALPHABET = 27
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         action,
    input  wire logic [SYM_W-1:0]   symbol,
    input  wire logic               final_symbol,
    output logic                    done,
    output logic [TOTAL_W-1:0]      match_total,
    output logic                    table_full
);

    localparam int NW     = $clog2(NODES);
    localparam int GDEPTH = NODES * ALPHABET;
    localparam int GW     = $clog2(GDEPTH);
    localparam int SW     = $clog2(ALPHABET);
    localparam logic [NW:0]    NODES_W  = (NW + 1)'(NODES);
    localparam logic [GW-1:0]  ALPHA_G  = GW'(ALPHABET);
    localparam logic [GW-1:0]  NODES_G  = GW'(NODES);
    localparam logic [GW-1:0]  CLR_LAST = GW'(GDEPTH - 1);
    localparam logic [SW-1:0]  SYM_LAST = SW'(ALPHABET - 1);
    localparam logic [8:0]     ALPHA_9  = 9'(ALPHABET);

    function automatic logic [GW-1:0] idx(input logic [NW-1:0] node, input logic [GW-1:0] s);
        idx = GW'(node) * ALPHA_G + s;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_cnt(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_cnt = s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
    endfunction

    state_t state_reg, state_next;
    logic [1:0]         act_reg, act_next;
    logic [SYM_W-1:0]   sym_reg, sym_next;
    logic               fin_reg, fin_next;
    logic [NW-1:0]      ins_reg, ins_next;
    logic [NW-1:0]      scan_reg, scan_next;
    logic [NW-1:0]      node_count_reg, node_count_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               ovf_reg, ovf_next;
    logic               built_reg, built_next;
    logic [NW:0]        head_reg, head_next;
    logic [NW:0]        tail_reg, tail_next;
    logic [SW-1:0]      s_reg, s_next;
    logic [NW-1:0]      u_reg, u_next;
    logic [NW-1:0]      f_reg, f_next;
    logic [NW-1:0]      p_reg, p_next;
    logic [COUNT_W-1:0] cf_reg, cf_next;
    logic [GW-1:0]      clr_reg, clr_next;
    logic               done_reg, done_next;
    logic [TOTAL_W-1:0] out_total_reg, out_total_next;
    logic               out_full_reg, out_full_next;

    // memory ports
    logic               g_we, f_we, c_we, q_we;
    logic [GW-1:0]      g_waddr, g_raddr;
    logic [NW-1:0]      g_wdata, g_rdata;
    logic [NW-1:0]      f_waddr, f_raddr, f_wdata, f_rdata;
    logic [NW-1:0]      c_waddr, c_raddr;
    logic [COUNT_W-1:0] c_wdata, c_rdata;
    logic [NW-1:0]      q_waddr, q_raddr, q_wdata, q_rdata;

    logic               sym_ok;
    logic [TOTAL_W:0]   sum;
    logic [GW-1:0]      s_g;

    mpam_ram #(.WIDTH(NW), .DEPTH(GDEPTH)) u_goto (
        .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
        .raddr(g_raddr), .rdata(g_rdata)
    );
    mpam_ram #(.WIDTH(NW), .DEPTH(NODES)) u_fail (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );
    mpam_ram #(.WIDTH(COUNT_W), .DEPTH(NODES)) u_count (
        .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rdata)
    );
    mpam_ram #(.WIDTH(NW), .DEPTH(NODES)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            ins_reg        <= '0;
            scan_reg       <= '0;
            node_count_reg <= '0;
            total_reg      <= '0;
            ovf_reg        <= 1'b0;
            built_reg      <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            s_reg          <= '0;
            clr_reg        <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ins_reg        <= ins_next;
            scan_reg       <= scan_next;
            node_count_reg <= node_count_next;
            total_reg      <= total_next;
            ovf_reg        <= ovf_next;
            built_reg      <= built_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            s_reg          <= s_next;
            clr_reg        <= clr_next;
            done_reg       <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        sym_reg       <= sym_next;
        fin_reg       <= fin_next;
        u_reg         <= u_next;
        f_reg         <= f_next;
        p_reg         <= p_next;
        cf_reg        <= cf_next;
        out_total_reg <= out_total_next;
        out_full_reg  <= out_full_next;
    end

    assign sym_ok = {4'b0, sym_reg} < ALPHA_9;
    assign s_g    = GW'(s_reg);
    assign sum    = {1'b0, total_reg} + {{(TOTAL_W - COUNT_W + 1){1'b0}}, c_rdata};

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        sym_next        = sym_reg;
        fin_next        = fin_reg;
        ins_next        = ins_reg;
        scan_next       = scan_reg;
        node_count_next = node_count_reg;
        total_next      = total_reg;
        ovf_next        = ovf_reg;
        built_next      = built_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        s_next          = s_reg;
        u_next          = u_reg;
        f_next          = f_reg;
        p_next          = p_reg;
        cf_next         = cf_reg;
        clr_next        = clr_reg;
        done_next       = 1'b0;
        out_total_next  = out_total_reg;
        out_full_next   = out_full_reg;
        g_we = 1'b0; g_waddr = '0; g_wdata = '0; g_raddr = '0;
        f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = '0;
        c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_raddr = '0;
        q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                g_we    = 1'b1;
                g_waddr = clr_reg;
                if (clr_reg < NODES_G)
                begin
                    f_we    = 1'b1;
                    f_waddr = clr_reg[NW-1:0];
                    c_we    = 1'b1;
                    c_waddr = clr_reg[NW-1:0];
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                act_next = action;
                sym_next = symbol;
                fin_next = final_symbol;
                if (start)
                begin
                    unique case (action)
                        ACT_PATTERN: state_next = built_reg ? ST_IDLE : ST_INS_RD;
                        ACT_END:     state_next = built_reg ? ST_IDLE : ST_END_RD;
                        ACT_BUILD:
                        begin
                            if (!built_reg)
                            begin
                                state_next = ST_R_RD;
                                s_next     = '0;
                                head_next  = '0;
                                tail_next  = '0;
                            end
                        end
                        ACT_QUERY:   state_next = ST_Q_RD;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            // pattern symbol
            ST_INS_RD:
            begin
                g_raddr    = idx(ins_reg, GW'(sym_reg));
                state_next = sym_ok ? ST_INS_WR : ST_IDLE;
            end
            ST_INS_WR:
            begin
                state_next = ST_IDLE;
                if (g_rdata != '0)
                begin
                    ins_next = g_rdata;
                end
                else if (({1'b0, node_count_reg} + 1'b1) < NODES_W)
                begin
                    node_count_next = node_count_reg + 1'b1;
                    ins_next        = node_count_reg + 1'b1;
                    g_we            = 1'b1;
                    g_waddr         = idx(ins_reg, GW'(sym_reg));
                    g_wdata         = node_count_reg + 1'b1;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            // end of pattern
            ST_END_RD:
            begin
                c_raddr    = ins_reg;
                state_next = ST_END_WR;
            end
            ST_END_WR:
            begin
                c_we       = 1'b1;
                c_waddr    = ins_reg;
                c_wdata    = sat_cnt(c_rdata, COUNT_W'(1));
                ins_next   = '0;
                state_next = ST_IDLE;
            end
            // query symbol
            ST_Q_RD:
            begin
                g_raddr    = idx(scan_reg, GW'(sym_reg));
                state_next = ST_Q_CNT;
            end
            ST_Q_CNT:
            begin
                scan_next  = sym_ok ? g_rdata : '0;
                c_raddr    = sym_ok ? g_rdata : '0;
                state_next = ST_Q_ACC;
            end
            ST_Q_ACC:
            begin
                state_next = ST_IDLE;
                total_next = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
                if (fin_reg)
                begin
                    done_next      = 1'b1;
                    out_total_next = total_next;
                    out_full_next  = ovf_reg;
                    total_next     = '0;
                    scan_next      = '0;
                end
            end
            // build: children of the root
            ST_R_RD:
            begin
                g_raddr    = s_g;
                state_next = ST_R_WT;
            end
            ST_R_WT:
            begin
                if (g_rdata != '0 && tail_reg < NODES_W)
                begin
                    q_we      = 1'b1;
                    q_waddr   = tail_reg[NW-1:0];
                    q_wdata   = g_rdata;
                    tail_next = tail_reg + 1'b1;
                end
                if (s_reg == SYM_LAST)
                begin
                    state_next = ST_B_QRD;
                end
                else
                begin
                    s_next     = s_reg + 1'b1;
                    state_next = ST_R_RD;
                end
            end
            // build: breadth-first walk
            ST_B_QRD:
            begin
                if (head_reg < tail_reg)
                begin
                    q_raddr    = head_reg[NW-1:0];
                    head_next  = head_reg + 1'b1;
                    state_next = ST_B_QWT;
                end
                else
                begin
                    built_next = 1'b1;
                    ins_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_B_QWT:
            begin
                u_next     = q_rdata;
                f_raddr    = q_rdata;
                state_next = ST_B_FWT;
            end
            ST_B_FWT:
            begin
                f_next     = f_rdata;
                c_raddr    = f_rdata;
                state_next = ST_B_CF;
            end
            ST_B_CF:
            begin
                cf_next    = c_rdata;
                c_raddr    = u_reg;
                state_next = ST_B_CU;
            end
            ST_B_CU:
            begin
                c_we       = 1'b1;
                c_waddr    = u_reg;
                c_wdata    = sat_cnt(c_rdata, cf_reg);
                s_next     = '0;
                state_next = ST_B_GRD;
            end
            ST_B_GRD:
            begin
                g_raddr    = idx(u_reg, s_g);
                state_next = ST_B_GP;
            end
            ST_B_GP:
            begin
                p_next     = g_rdata;
                g_raddr    = idx(f_reg, s_g);
                state_next = ST_B_GV;
            end
            ST_B_GV:
            begin
                if (p_reg == '0)
                begin
                    g_we    = 1'b1;
                    g_waddr = idx(u_reg, s_g);
                    g_wdata = g_rdata;
                end
                else
                begin
                    f_we    = 1'b1;
                    f_waddr = p_reg;
                    f_wdata = g_rdata;
                    if (tail_reg < NODES_W)
                    begin
                        q_we      = 1'b1;
                        q_waddr   = tail_reg[NW-1:0];
                        q_wdata   = p_reg;
                        tail_next = tail_reg + 1'b1;
                    end
                end
                if (s_reg == SYM_LAST)
                begin
                    state_next = ST_B_QRD;
                end
                else
                begin
                    s_next     = s_reg + 1'b1;
                    state_next = ST_B_GRD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign match_total = out_total_reg;
    assign table_full  = out_full_reg;

    // checks
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_Q_ACC && fin_reg))
        else $error("result strobe without a final query step");

    a_built_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        built_reg |=> built_reg)
        else $error("built flag dropped");

    a_nodes_grow: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> node_count_reg >= $past(node_count_reg))
        else $error("node count went down");

endmodule
`default_nettype wire

### design/mpam_ram.sv
`default_nettype none
module mpam_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire
